[hw/rtl/four_neighbour_grid_average_unit_assert.svh]
// Assertion macros shared by the grid average unit's RTL files.
// No dependencies; taken in by `include where a module checks itself.
`ifndef FOUR_NEIGHBOUR_GRID_AVERAGE_UNIT_ASSERT_SVH
`define FOUR_NEIGHBOUR_GRID_AVERAGE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FNGA_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FNGA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/fnga_pkg.sv]
// Shared constants, types and register indexes of the grid average unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package fnga_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int DATA_W      = 8;
    localparam int POS_W       = 10;
    localparam int WORD_W      = 2 * DATA_W;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 40;
    localparam int M_PAD_W     = M_TDATA_W - (2 * DATA_W + 2 * POS_W);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    // Position of a cell's row within the frame.
    typedef enum logic [1:0] {
        ROW_FIRST,
        ROW_SECOND,
        ROW_INNER,
        ROW_LAST
    } t_row_kind;

    // One classified cell as it travels from the front end to the back end.
    typedef struct packed {
        logic [DATA_W-1:0] temperature;
        logic [DATA_W-1:0] humidity;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        t_row_kind         kind;
        logic              col_first;
        logic              col_second;
        logic              col_last;
    } t_item;

endpackage

`default_nettype wire

[hw/rtl/fnga_front.sv]
// Front end: configuration registers, raster position counters and
// classification of each accepted cell. Depends on fnga_pkg.
`default_nettype none

module fnga_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [fnga_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [fnga_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  wire logic [fnga_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    input  wire logic                            i_queue_full,
    output logic                                 o_push,
    output fnga_pkg::t_item                      o_item
);
    import fnga_pkg::*;

    logic [COL_W-1:0] r_w_m1, n_w_m1;
    logic [ROW_W-1:0] r_h_m1, n_h_m1;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             accept;
    logic             col_last;
    t_row_kind        kind;

    // Out-of-range sizes act as the nearest legal size.
    function automatic logic [31:0] clamp_dim(input logic [CFG_W-1:0] value,
                                              input logic [31:0] max_value);
        logic [31:0] v;
        v = 32'(value);
        if (v < 32'd3) begin
            return 32'd3;
        end
        if (v > max_value) begin
            return max_value;
        end
        return v;
    endfunction

    assign o_s_axis_tready = !i_queue_full;
    assign accept          = i_s_axis_tvalid && !i_queue_full;
    assign o_push          = accept;
    assign col_last        = (r_col == r_w_m1);

    always_comb begin
        if (r_row == '0) begin
            kind = ROW_FIRST;
        end else if (r_row == ROW_W'(1)) begin
            kind = ROW_SECOND;
        end else if (r_row == r_h_m1) begin
            kind = ROW_LAST;
        end else begin
            kind = ROW_INNER;
        end
    end

    always_comb begin
        o_item.temperature = i_s_axis_tdata[DATA_W-1:0];
        o_item.humidity    = i_s_axis_tdata[2*DATA_W-1:DATA_W];
        o_item.column      = r_col;
        o_item.row         = r_row;
        o_item.kind        = kind;
        o_item.col_first   = (r_col == '0);
        o_item.col_second  = (r_col == COL_W'(1));
        o_item.col_last    = col_last;
    end

    always_comb begin
        n_w_m1 = r_w_m1;
        n_h_m1 = r_h_m1;
        n_col  = r_col;
        n_row  = r_row;
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_GRID_WIDTH: begin
                    n_w_m1 = COL_W'(clamp_dim(i_cfg_wdata, 32'(MAX_WIDTH)) - 32'd1);
                end
                REG_GRID_HEIGHT: begin
                    n_h_m1 = ROW_W'(clamp_dim(i_cfg_wdata, 32'(MAX_HEIGHT)) - 32'd1);
                end
                default: begin
                    n_w_m1 = r_w_m1;
                end
            endcase
            // Any register write starts a new frame.
            n_col = '0;
            n_row = '0;
        end else if (accept) begin
            if (col_last) begin
                n_col = '0;
                n_row = (r_row == r_h_m1) ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_m1 <= COL_W'(MAX_WIDTH - 1);
            r_h_m1 <= ROW_W'(MAX_HEIGHT - 1);
            r_col  <= '0;
            r_row  <= '0;
        end else begin
            r_w_m1 <= n_w_m1;
            r_h_m1 <= n_h_m1;
            r_col  <= n_col;
            r_row  <= n_row;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/fnga_queue.sv]
// Short first-in first-out queue of classified cells between the front
// and back ends. Depends on fnga_pkg and the assertion macro header.
`default_nettype none
`include "four_neighbour_grid_average_unit_assert.svh"

module fnga_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire fnga_pkg::t_item i_item,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_head_valid,
    output fnga_pkg::t_item      o_head
);
    import fnga_pkg::*;

    t_item             r_entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QPTR_W:0]   r_count, n_count;

    assign o_full       = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_entries[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + (QPTR_W + 1)'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr_ptr] <= i_item;
        end
    end

    `FNGA_ASSERT_HOLDS(a_no_push_when_full, i_clk, i_rst_n, i_push, !o_full, "push into a full queue")
    `FNGA_ASSERT_HOLDS(a_no_pop_when_empty, i_clk, i_rst_n, i_pop, r_count != '0, "pop from an empty queue")
    `FNGA_ASSERT_NEXT(a_count_grows, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "queue count did not grow on push")

endmodule

`default_nettype wire

[hw/rtl/fnga_back.sv]
// Back end: two line-store banks, neighbour gathering, the four-way average
// and the output register. Depends on fnga_pkg and the assertion macro header.
`default_nettype none
`include "four_neighbour_grid_average_unit_assert.svh"

module fnga_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_head_valid,
    input  wire fnga_pkg::t_item                 i_head,
    output logic                                 o_pop,
    input  wire logic                            i_m_axis_tready,
    output logic                                 o_m_axis_tvalid,
    output logic [fnga_pkg::M_TDATA_W-1:0]       o_m_axis_tdata,
    output logic                                 o_m_axis_tlast
);
    import fnga_pkg::*;

    // Line store: bank 0 holds even rows, bank 1 odd rows.
    logic [WORD_W-1:0] r_mem0 [MAX_WIDTH];
    logic [WORD_W-1:0] r_mem1 [MAX_WIDTH];
    logic [WORD_W-1:0] r_q0, r_q1;

    t_item             r_s2;
    logic              r_s2_valid, n_s2_valid;
    logic              r_phase, n_phase;
    logic [WORD_W-1:0] r_wrap;
    logic [WORD_W-1:0] r_h1, r_h2;
    logic [WORD_W-1:0] r_row_first, r_prev_first, r_prev_last;

    logic              r_out_valid, n_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;
    logic              r_out_last;

    logic              load;
    logic              s2_done;
    logic              out_load_ok;
    logic              emit;
    logic              head_par;
    logic [COL_W-1:0]  addr_other;
    logic [COL_W-1:0]  addr0, addr1;
    logic [WORD_W-1:0] head_word;

    logic [WORD_W-1:0] up_w, nb_w, left_w, right_w, cur_w;
    logic [9:0]        t_sum, t_adj, h_sum;
    logic [DATA_W-1:0] res_temp, res_hum;
    logic [ROW_W-1:0]  res_row;
    logic              res_last;

    // ---------------- issue side: pop from the queue, read and write banks
    assign out_load_ok = !r_out_valid || i_m_axis_tready;

    always_comb begin
        s2_done = 1'b0;
        if (r_s2_valid) begin
            case (r_s2.kind)
                ROW_FIRST:  s2_done = 1'b1;
                ROW_SECOND: s2_done = out_load_ok;
                ROW_INNER:  s2_done = out_load_ok;
                ROW_LAST:   s2_done = out_load_ok && r_phase;
                default:    s2_done = 1'b1;
            endcase
        end
    end

    assign load  = i_head_valid && (!r_s2_valid || s2_done);
    assign o_pop = load;

    assign head_par   = i_head.row[0];
    assign head_word  = {i_head.temperature, i_head.humidity};
    assign addr_other = (i_head.kind == ROW_SECOND) ? i_head.column
                                                    : i_head.column + COL_W'(1);
    assign addr0      = head_par ? addr_other : i_head.column;
    assign addr1      = head_par ? i_head.column : addr_other;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_q0 <= r_mem0[addr0];
            r_q1 <= r_mem1[addr1];
            if (!head_par) begin
                r_mem0[i_head.column] <= head_word;
            end else begin
                r_mem1[i_head.column] <= head_word;
            end
        end
    end

    // ---------------- compute side
    assign up_w  = r_s2.row[0] ? r_q1 : r_q0;
    assign nb_w  = r_s2.row[0] ? r_q0 : r_q1;
    assign cur_w = {r_s2.temperature, r_s2.humidity};

    assign left_w  = (r_s2.col_first || r_s2.col_second) ? r_wrap : r_h2;
    assign right_w = r_s2.col_last ? r_wrap : nb_w;

    always_comb begin
        t_sum = {{2{up_w[15]}}, up_w[15:8]} + {{2{left_w[15]}}, left_w[15:8]}
              + {{2{right_w[15]}}, right_w[15:8]} + {{2{cur_w[15]}}, cur_w[15:8]};
        // Bias negative sums by three so the shift truncates toward zero.
        t_adj = t_sum + {8'b0, t_sum[9], t_sum[9]};
        h_sum = {2'b0, up_w[7:0]} + {2'b0, left_w[7:0]}
              + {2'b0, right_w[7:0]} + {2'b0, cur_w[7:0]};
    end

    always_comb begin
        res_temp = t_adj[9:2];
        res_hum  = h_sum[9:2];
        res_row  = r_s2.row - ROW_W'(1);
        res_last = 1'b0;
        case (r_s2.kind)
            ROW_SECOND: begin
                res_temp = nb_w[15:8];
                res_hum  = nb_w[7:0];
                res_row  = '0;
            end
            ROW_LAST: begin
                if (r_phase) begin
                    res_temp = r_s2.temperature;
                    res_hum  = r_s2.humidity;
                    res_row  = r_s2.row;
                    res_last = r_s2.col_last;
                end
            end
            default: begin
                res_last = 1'b0;
            end
        endcase
    end

    assign emit = r_s2_valid && (r_s2.kind != ROW_FIRST) && out_load_ok;

    always_comb begin
        n_s2_valid = r_s2_valid;
        if (load) begin
            n_s2_valid = 1'b1;
        end else if (s2_done) begin
            n_s2_valid = 1'b0;
        end
        n_phase = r_phase;
        if (emit && r_s2.kind == ROW_LAST) begin
            n_phase = !r_phase;
        end
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s2_valid  <= n_s2_valid;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_s2 <= i_head;
            r_wrap <= i_head.col_first ? r_prev_last : r_prev_first;
            r_h1 <= nb_w;
            r_h2 <= r_h1;
            if (i_head.col_first) begin
                r_row_first <= head_word;
            end
            if (i_head.col_last) begin
                r_prev_first <= r_row_first;
                r_prev_last  <= head_word;
            end
        end
        if (emit) begin
            r_out_data <= {{M_PAD_W{1'b0}}, POS_W'(res_row), POS_W'(r_s2.column),
                           res_hum, res_temp};
            r_out_last <= res_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    `FNGA_ASSERT_HOLDS(a_phase_only_last, i_clk, i_rst_n, r_phase, r_s2_valid && (r_s2.kind == ROW_LAST), "second result phase outside the last row")
    `FNGA_ASSERT_NEXT(a_second_result_follows, i_clk, i_rst_n, r_s2_valid && (r_s2.kind == ROW_LAST) && !r_phase && out_load_ok, r_phase && r_out_valid, "last row cell lost its second result")
    `FNGA_ASSERT_HOLDS(a_stall_means_busy, i_clk, i_rst_n, i_head_valid && !o_pop, r_s2_valid && !s2_done, "queue head held while the compute stage was free")

endmodule

`default_nettype wire

[hw/rtl/four_neighbour_grid_average_unit.sv]
// Four-neighbour average over a grid with wrapping columns: top level.
// Depends on fnga_pkg, fnga_front, fnga_queue and fnga_back.
//
// Cells arrive in raster order on the slave stream, one request per cell, and
// every cell of an inner row is replaced by the average of its upper, lower,
// left and right neighbours (temperature truncated toward zero, humidity
// rounded down); columns wrap, and the first and last rows pass through.
// Cell (c, r) leaves when cell (c, r+1) arrives, so the first row gives no
// output while it streams in, and each cell of the last row gives two output
// requests: its computed upper neighbour and then itself, the latter with
// tlast high on the frame's final cell. The block takes one cell per clock
// cycle while the output is not stalled, but a last-row cell holds the
// compute stage for two results, as the single output register issues one
// result per cycle. A four-entry queue separates the classifying front end
// from the back end, so input keeps flowing while a result waits; unstalled,
// a releasing cell passes the queue, compute stage and output register. The
// line store is two banks of MAX_WIDTH 16-bit words, both read and one
// written per loaded cell; it needs no clearing after reset. Writing either
// size register restarts the frame and must only happen while idle; sizes
// below 3 act as 3 and sizes above the maximum act as the maximum.
`default_nettype none

module four_neighbour_grid_average_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [fnga_pkg::CFG_IDX_W-1:0]  i_cfg_index,   // 0 grid_width, 1 grid_height
    input  wire logic [fnga_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // [7:0] in_temperature, [15:8] in_humidity
    input  wire logic [fnga_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // [7:0] out_temperature, [15:8] out_humidity, [25:16] out_column,
    // [35:26] out_row, [39:36] zero
    output logic [fnga_pkg::M_TDATA_W-1:0]       o_m_axis_tdata,
    output logic                                 o_m_axis_tlast  // frame_last
);
    import fnga_pkg::*;

    logic  queue_full;
    logic  push;
    t_item push_item;
    logic  pop;
    logic  head_valid;
    t_item head_item;

    // Front end: keeps the raster position and tags each cell with its row
    // kind and column edges before it joins the queue.
    fnga_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_queue_full    (queue_full),
        .o_push          (push),
        .o_item          (push_item)
    );

    fnga_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_item       (push_item),
        .o_full       (queue_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head_item)
    );

    // Back end: the line store, the neighbour window and the output register.
    fnga_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_valid    (head_valid),
        .i_head          (head_item),
        .o_pop           (pop),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

`default_nettype wire
